// ----- rtl/monomial_order_compare_assert.svh -----
`ifndef MONOMIAL_ORDER_COMPARE_ASSERT_SVH
`define MONOMIAL_ORDER_COMPARE_ASSERT_SVH

// checked at every rising edge outside reset
`define MOC_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define MOC_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- rtl/moc_pkg.sv -----
package moc_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;

    localparam logic [1:0] REG_ORDER_MODE = 2'd0;
    localparam logic [1:0] REG_NUM_VARS   = 2'd1;
    localparam logic [1:0] REG_ELIM_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] TERM_DEGREVLEX     = 4'd0;
    localparam logic [CFG_W-1:0] TERM_DEGLEX        = 4'd1;
    localparam logic [CFG_W-1:0] TERM_LEX           = 4'd2;
    localparam logic [CFG_W-1:0] TERM_BLK_DEGREVLEX = 4'd3;
    localparam logic [CFG_W-1:0] TERM_BLK_DEGLEX    = 4'd4;
    localparam logic [CFG_W-1:0] TERM_BLK_LEX       = 4'd5;
    localparam logic [CFG_W-1:0] TERM_SPLIT_REVREV  = 4'd6;
    localparam logic [CFG_W-1:0] TERM_SPLIT_DEGREV  = 4'd7;
    localparam logic [CFG_W-1:0] TERM_SPLIT_LEXREV  = 4'd8;
    localparam logic [CFG_W-1:0] TERM_ELIM          = 4'd9;

    localparam logic [CFG_W-1:0] RST_ORDER_MODE = TERM_DEGREVLEX;
    localparam logic [CFG_W-1:0] RST_NUM_VARS   = 4'd8;
    localparam logic [CFG_W-1:0] RST_ELIM_COUNT = 4'd0;

    typedef logic signed [1:0] res_t;

    localparam res_t RES_GT = 2'sb01;
    localparam res_t RES_EQ = 2'sb00;
    localparam res_t RES_LT = 2'sb11;

    typedef struct packed {
        logic gt;
        logic lt;
        logic in_blk;
        logic in_rest;
        logic in_head;
        logic is_last;
    } lane_flags_t;

endpackage

// ----- rtl/moc_lane.sv -----
module moc_lane #(
    parameter int LANE     = 0,
    parameter int EXP_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      load,
    input  logic [EXP_BITS-1:0]       exp_a,
    input  logic [EXP_BITS-1:0]       exp_b,
    input  logic [moc_pkg::CFG_W-1:0] num_vars,
    input  logic [moc_pkg::CFG_W-1:0] elim_count,
    output logic [EXP_BITS-1:0]       exp_a_q,
    output logic [EXP_BITS-1:0]       exp_b_q,
    output moc_pkg::lane_flags_t      flags_q
);
    import moc_pkg::*;

    localparam logic [CFG_W:0] Idx = (CFG_W+1)'(LANE);

    logic [CFG_W:0]      n_ext;
    logic [CFG_W:0]      k_ext;
    logic                in_use;
    logic [EXP_BITS-1:0] exp_a_next;
    logic [EXP_BITS-1:0] exp_b_next;
    lane_flags_t         flags_next;
    logic [EXP_BITS-1:0] exp_a_reg;
    logic [EXP_BITS-1:0] exp_b_reg;
    lane_flags_t         flags_reg;

    always_comb begin
        n_ext      = {1'b0, num_vars};
        k_ext      = {1'b0, elim_count};
        in_use     = Idx < n_ext;
        exp_a_next = in_use ? exp_a : '0;
        exp_b_next = in_use ? exp_b : '0;
        flags_next.gt      = exp_a_next > exp_b_next;
        flags_next.lt      = exp_a_next < exp_b_next;
        flags_next.in_blk  = Idx < k_ext;
        flags_next.in_rest = in_use && (Idx >= k_ext);
        flags_next.in_head = (Idx + 1'b1) < n_ext;
        flags_next.is_last = (Idx + 1'b1) == n_ext;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            exp_a_reg <= exp_a_next;
            exp_b_reg <= exp_b_next;
            flags_reg <= flags_next;
        end
    end

    assign exp_a_q = exp_a_reg;
    assign exp_b_q = exp_b_reg;
    assign flags_q = flags_reg;

endmodule

// ----- rtl/moc_merge.sv -----
module moc_merge #(
    parameter int MAX_VARS = 8,
    parameter int EXP_BITS = 8
) (
    input  logic                                      aclk,
    input  logic                                      load,
    input  logic [moc_pkg::CFG_W-1:0]                 order_mode,
    input  logic [MAX_VARS-1:0][EXP_BITS-1:0]         exp_a,
    input  logic [MAX_VARS-1:0][EXP_BITS-1:0]         exp_b,
    input  moc_pkg::lane_flags_t [MAX_VARS-1:0]       flags,
    output moc_pkg::res_t                             result_q
);
    import moc_pkg::*;

    localparam int SUM_W = EXP_BITS + $clog2(MAX_VARS + 1);

    logic [MAX_VARS-1:0] gt, lt, m_all, m_blk, m_rest, m_head;
    logic [SUM_W-1:0]    ta, tb, ea, eb, ha, hb, ra, rb;
    res_t c_t, c_e, c_h, c_r, c_last;
    res_t lex_all, lex_head, lex_blk, rev_all, rev_head, rev_blk, rev_rest;
    res_t result_next;
    res_t result_reg;

    function automatic res_t cmp_sum(input logic [SUM_W-1:0] x, input logic [SUM_W-1:0] y);
        return (x > y) ? RES_GT : ((x < y) ? RES_LT : RES_EQ);
    endfunction

    function automatic res_t pick(input res_t p, input res_t q);
        return (p != RES_EQ) ? p : q;
    endfunction

    // first differing variable in mask decides, larger exponent wins
    function automatic res_t lex_sel(input logic [MAX_VARS-1:0] mask,
                                     input logic [MAX_VARS-1:0] g,
                                     input logic [MAX_VARS-1:0] l);
        res_t r;
        r = RES_EQ;
        for (int i = MAX_VARS - 1; i >= 0; i--) begin
            if (mask[i] && (g[i] || l[i])) begin
                r = g[i] ? RES_GT : RES_LT;
            end
        end
        return r;
    endfunction

    // last differing variable in mask decides, smaller exponent wins
    function automatic res_t rev_sel(input logic [MAX_VARS-1:0] mask,
                                     input logic [MAX_VARS-1:0] g,
                                     input logic [MAX_VARS-1:0] l);
        res_t r;
        r = RES_EQ;
        for (int i = 0; i < MAX_VARS; i++) begin
            if (mask[i] && (g[i] || l[i])) begin
                r = l[i] ? RES_GT : RES_LT;
            end
        end
        return r;
    endfunction

    always_comb begin
        ta = '0; tb = '0; ea = '0; eb = '0;
        ha = '0; hb = '0; ra = '0; rb = '0;
        c_last = RES_EQ;
        for (int i = 0; i < MAX_VARS; i++) begin
            gt[i]     = flags[i].gt;
            lt[i]     = flags[i].lt;
            m_all[i]  = 1'b1;
            m_blk[i]  = flags[i].in_blk;
            m_rest[i] = flags[i].in_rest;
            m_head[i] = flags[i].in_head;
            ta = ta + SUM_W'(exp_a[i]);
            tb = tb + SUM_W'(exp_b[i]);
            if (flags[i].in_blk) begin
                ea = ea + SUM_W'(exp_a[i]);
                eb = eb + SUM_W'(exp_b[i]);
            end
            if (flags[i].in_head) begin
                ha = ha + SUM_W'(exp_a[i]);
                hb = hb + SUM_W'(exp_b[i]);
            end
            if (flags[i].in_rest) begin
                ra = ra + SUM_W'(exp_a[i]);
                rb = rb + SUM_W'(exp_b[i]);
            end
            if (flags[i].is_last) begin
                c_last = flags[i].gt ? RES_GT : (flags[i].lt ? RES_LT : RES_EQ);
            end
        end
    end

    always_comb begin
        c_t      = cmp_sum(ta, tb);
        c_e      = cmp_sum(ea, eb);
        c_h      = cmp_sum(ha, hb);
        c_r      = cmp_sum(ra, rb);
        // unused lanes carry zero exponents, so they never differ
        lex_all  = lex_sel(m_all, gt, lt);
        lex_head = lex_sel(m_head, gt, lt);
        lex_blk  = lex_sel(m_blk, gt, lt);
        rev_all  = rev_sel(m_all, gt, lt);
        rev_head = rev_sel(m_head, gt, lt);
        rev_blk  = rev_sel(m_blk, gt, lt);
        rev_rest = rev_sel(m_rest, gt, lt);
    end

    always_comb begin
        case (order_mode)
            TERM_DEGREVLEX:     result_next = pick(c_t, rev_all);
            TERM_DEGLEX:        result_next = pick(c_t, lex_all);
            TERM_LEX:           result_next = lex_all;
            TERM_BLK_DEGREVLEX: result_next = pick(c_h, pick(rev_head, c_t));
            TERM_BLK_DEGLEX:    result_next = pick(c_h, pick(lex_head, c_t));
            TERM_BLK_LEX:       result_next = pick(lex_head, c_last);
            TERM_SPLIT_REVREV:  result_next = pick(c_e, pick(rev_blk, pick(c_r, rev_rest)));
            TERM_SPLIT_DEGREV:  result_next = pick(c_e, pick(lex_blk, pick(c_r, rev_rest)));
            TERM_SPLIT_LEXREV:  result_next = pick(lex_blk, pick(c_r, rev_rest));
            TERM_ELIM:          result_next = pick(c_e, pick(c_t, rev_all));
            default:            result_next = lex_all;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result_q = result_reg;

endmodule

// ----- rtl/monomial_order_compare.sv -----
// Two-stage pipeline: per-variable lanes, then a merge stage with the result register.
// Accepted items are registered in the lanes, then in the merge result register.
// Throughput: one item per cycle unless stalled; one pass through lanes and merge.
// Reset (aresetn low, synchronous): pipeline emptied, order_mode = 0, num_vars = 8,
// elim_count = 0.
module monomial_order_compare #(
    parameter int MAX_VARS = 8,
    parameter int EXP_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [63:0]                s_exponents_a,
    input  logic [63:0]                s_exponents_b,
    output logic                       m_valid,
    input  logic                       m_ready,
    output moc_pkg::res_t              m_order_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [moc_pkg::ADDR_W-1:0] paddr,
    input  logic [moc_pkg::DATA_W-1:0] pwdata,
    output logic [moc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import moc_pkg::*;

    localparam int              WIDE_W = 64 + MAX_VARS * EXP_BITS;
    localparam logic [CFG_W-1:0] MaxN  = CFG_W'(MAX_VARS);

    logic [CFG_W-1:0] order_mode_reg, order_mode_next;
    logic [CFG_W-1:0] num_vars_reg, num_vars_next;
    logic [CFG_W-1:0] elim_count_reg, elim_count_next;
    logic [CFG_W-1:0] n_eff, k_eff;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    logic v1_reg, v1_next, v2_reg, v2_next;
    logic adv2;

    logic [WIDE_W-1:0]                wide_a, wide_b;
    logic [MAX_VARS-1:0][EXP_BITS-1:0] lane_a, lane_b;
    lane_flags_t [MAX_VARS-1:0]        lane_flags;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        order_mode_next = order_mode_reg;
        num_vars_next   = num_vars_reg;
        elim_count_next = elim_count_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_ORDER_MODE: order_mode_next = pwdata[CFG_W-1:0];
                REG_NUM_VARS:   num_vars_next   = pwdata[CFG_W-1:0];
                REG_ELIM_COUNT: elim_count_next = pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ORDER_MODE: prdata = DATA_W'(order_mode_reg);
            REG_NUM_VARS:   prdata = DATA_W'(num_vars_reg);
            REG_ELIM_COUNT: prdata = DATA_W'(elim_count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= RST_ORDER_MODE;
            num_vars_reg   <= RST_NUM_VARS;
            elim_count_reg <= RST_ELIM_COUNT;
        end else begin
            order_mode_reg <= order_mode_next;
            num_vars_reg   <= num_vars_next;
            elim_count_reg <= elim_count_next;
        end
    end

    always_comb begin
        if (num_vars_reg > MaxN) begin
            n_eff = MaxN;
        end else if (num_vars_reg == '0) begin
            n_eff = CFG_W'(1);
        end else begin
            n_eff = num_vars_reg;
        end
        k_eff = (elim_count_reg > n_eff) ? n_eff : elim_count_reg;
    end

    // pipeline control
    assign adv2    = !v2_reg || m_ready;
    assign s_ready = !v1_reg || adv2;
    assign v1_next = s_ready ? s_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // bits past the 64-bit word read as zero
    assign wide_a = {{(WIDE_W-64){1'b0}}, s_exponents_a};
    assign wide_b = {{(WIDE_W-64){1'b0}}, s_exponents_b};

    for (genvar i = 0; i < MAX_VARS; i++) begin : g_lane
        moc_lane #(
            .LANE     (i),
            .EXP_BITS (EXP_BITS)
        ) u_lane (
            .aclk       (aclk),
            .load       (s_ready),
            .exp_a      (wide_a[i*EXP_BITS +: EXP_BITS]),
            .exp_b      (wide_b[i*EXP_BITS +: EXP_BITS]),
            .num_vars   (n_eff),
            .elim_count (k_eff),
            .exp_a_q    (lane_a[i]),
            .exp_b_q    (lane_b[i]),
            .flags_q    (lane_flags[i])
        );
    end

    moc_merge #(
        .MAX_VARS (MAX_VARS),
        .EXP_BITS (EXP_BITS)
    ) u_merge (
        .aclk       (aclk),
        .load       (adv2),
        .order_mode (order_mode_reg),
        .exp_a      (lane_a),
        .exp_b      (lane_b),
        .flags      (lane_flags),
        .result_q   (m_order_result)
    );

    assign m_valid = v2_reg;

endmodule

// ----- rtl/moc_checker.sv -----
`include "monomial_order_compare_assert.svh"

module moc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [1:0] m_order_result
);

    `MOC_ASSERT_ANY(a_empty_after_reset, $past(!aresetn) |-> !m_valid, "m_valid set right after reset")
    `MOC_ASSERT_CLK(a_code_legal, m_valid |-> (m_order_result != 2'sb10), "illegal result code")
    `MOC_ASSERT_CLK(a_ready_when_out_empty, !m_valid |-> s_ready, "input stalled with empty output")
    `MOC_ASSERT_CLK(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_order_result)), "stalled result changed")

endmodule

bind monomial_order_compare moc_checker u_moc_checker (.*);
